// File: sv/lpsp_pkg.sv
`timescale 1ns / 1ps

package lpsp_pkg;

  localparam int unsigned WIN_LEN        = 7;
  localparam int unsigned CNT_W          = 3;
  localparam int unsigned FRAC_BITS      = 4;
  localparam int unsigned ANGLE_BINS_DEF = 360;
  localparam logic [7:0]  SUM_MOD        = 8'd255;

  // One decoded measurement, as carried from the window logic to the result register.
  typedef struct packed {
    logic [7:0]  sync_byte;
    logic [15:0] angle_fixed;
    logic [11:0] degree_index;
    logic        angle_in_range;
    logic [15:0] distance_cm;
    logic [7:0]  signal_strength;
  } meas_t;

endpackage

// File: sv/lidar_packet_sync_parser_unit.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// rx       in         rx_valid_i/rx_ready_o  rx_byte_i
// out      out        out_valid_o/out_ready_i sync_byte_o, angle_fixed_o, degree_index_o,
//                                            angle_in_range_o, distance_cm_o, signal_strength_o
//
// One byte is taken per cycle while rx_ready_o is high; a measurement appears in the
// cycle after the byte that completes a packet with a valid checksum. The window update
// and checksum fold sit between the window registers and the result register.
// Reset clears the fill count and the result valid flag; window bytes are not reset.
// rx_ready_o drops only while a measurement waits in the result register and
// out_ready_i is low.

module lidar_packet_sync_parser_unit #(
  parameter int unsigned ANGLE_BINS = lpsp_pkg::ANGLE_BINS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  sync_byte_o,
  output logic [15:0] angle_fixed_o,
  output logic [11:0] degree_index_o,
  output logic        angle_in_range_o,
  output logic [15:0] distance_cm_o,
  output logic [7:0]  signal_strength_o
);
  import lpsp_pkg::*;

  logic  take;
  logic  match;
  logic  space;
  meas_t meas_new;
  meas_t meas_out;

  assign rx_ready_o = space;
  assign take       = rx_valid_i && space;

  lpsp_window #(
    .ANGLE_BINS(ANGLE_BINS)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .rx_byte_i(rx_byte_i),
    .match_o  (match),
    .meas_o   (meas_new)
  );

  lpsp_result_reg u_result (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (take && match),
    .meas_i     (meas_new),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .meas_o     (meas_out)
  );

  assign sync_byte_o       = meas_out.sync_byte;
  assign angle_fixed_o     = meas_out.angle_fixed;
  assign degree_index_o    = meas_out.degree_index;
  assign angle_in_range_o  = meas_out.angle_in_range;
  assign distance_cm_o     = meas_out.distance_cm;
  assign signal_strength_o = meas_out.signal_strength;

endmodule

// File: sv/lpsp_window.sv
`timescale 1ns / 1ps

module lpsp_window #(
  parameter int unsigned ANGLE_BINS = lpsp_pkg::ANGLE_BINS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  logic [7:0]      rx_byte_i,
  output logic            match_o,
  output lpsp_pkg::meas_t meas_o
);
  import lpsp_pkg::*;

  localparam logic [16:0] AngleLimit = 17'(ANGLE_BINS * (2 ** FRAC_BITS));

  logic [7:0]       win_q [WIN_LEN];
  logic [7:0]       win_d [WIN_LEN];
  logic [CNT_W-1:0] count_q, count_d;
  logic             full_d;
  logic [10:0]      sum;
  logic [8:0]       fold;
  logic [7:0]       sum_mod;
  logic [15:0]      az;

  always_comb begin
    win_d = win_q;
    if (count_q < CNT_W'(WIN_LEN)) begin
      win_d[count_q] = rx_byte_i;
    end else begin
      for (int k = 0; k < WIN_LEN - 1; k++) begin
        win_d[k] = win_q[k + 1];
      end
      win_d[WIN_LEN - 1] = rx_byte_i;
    end
  end

  assign full_d = (count_q >= CNT_W'(WIN_LEN - 1));

  // 256 is 1 modulo 255, so the high bits fold onto the low byte; one subtract finishes it.
  always_comb begin
    sum = '0;
    for (int k = 0; k < WIN_LEN - 1; k++) begin
      sum = sum + 11'(win_d[k]);
    end
    fold = 9'(sum[7:0]) + 9'(sum[10:8]);
    if (fold >= 9'(SUM_MOD)) begin
      sum_mod = 8'(fold - 9'(SUM_MOD));
    end else begin
      sum_mod = fold[7:0];
    end
  end

  assign match_o = full_d && (sum_mod == win_d[WIN_LEN - 1]);

  assign az = {win_d[2], win_d[1]};

  always_comb begin
    meas_o.sync_byte       = win_d[0];
    meas_o.angle_fixed     = az;
    meas_o.degree_index    = az[15:FRAC_BITS];
    meas_o.angle_in_range  = ({1'b0, az} < AngleLimit);
    meas_o.distance_cm     = {win_d[4], win_d[3]};
    meas_o.signal_strength = win_d[5];
  end

  always_comb begin
    count_d = count_q;
    if (match_o) begin
      count_d = '0;
    end else if (count_q < CNT_W'(WIN_LEN)) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (take_i) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      win_q <= win_d;
    end
  end

endmodule

// File: sv/lpsp_result_reg.sv
`timescale 1ns / 1ps

module lpsp_result_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  lpsp_pkg::meas_t meas_i,
  output logic            space_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lpsp_pkg::meas_t meas_o
);
  import lpsp_pkg::*;

  logic  valid_q, valid_d;
  meas_t meas_q;

  // The register has room when empty or when its transaction completes this cycle.
  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      meas_q <= meas_i;
    end
  end

  assign out_valid_o = valid_q;
  assign meas_o      = meas_q;

endmodule

// File: tb/lidar_packet_sync_checker.sv
`timescale 1ns / 1ps

module lidar_packet_sync_checker #(
  parameter int unsigned ANGLE_BINS = lpsp_pkg::ANGLE_BINS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  input  logic        rx_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  sync_byte_i,
  input  logic [15:0] angle_fixed_i,
  input  logic [11:0] degree_index_i,
  input  logic        angle_in_range_i,
  input  logic [15:0] distance_cm_i,
  input  logic [7:0]  signal_strength_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  import lpsp_pkg::*;

  logic [7:0]  window_q [WIN_LEN];
  int unsigned fill_q;
  meas_t       meas_queue [$];
  int unsigned errors = 0;

  assign fail_count_o = errors;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(input string field, input int unsigned got,
                               input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", field, got, want));
    end
  endtask

  // Shifts one received byte into the packet window and decodes a measurement
  // when the seven held bytes carry a matching additive checksum.
  function automatic bit absorb_byte(input logic [7:0] b, output meas_t m);
    int unsigned total;
    logic [15:0] az;
    m = '0;
    if (fill_q < WIN_LEN) begin
      window_q[fill_q] = b;
      fill_q++;
    end else begin
      for (int k = 0; k < WIN_LEN - 1; k++) window_q[k] = window_q[k + 1];
      window_q[WIN_LEN - 1] = b;
    end
    if (fill_q != WIN_LEN) return 1'b0;
    total = 0;
    for (int k = 0; k < WIN_LEN - 1; k++) total += window_q[k];
    if ((total % SUM_MOD) != window_q[WIN_LEN - 1]) return 1'b0;
    az = {window_q[2], window_q[1]};
    m.sync_byte       = window_q[0];
    m.angle_fixed     = az;
    m.degree_index    = az[15:FRAC_BITS];
    m.angle_in_range  = (az < ANGLE_BINS * (1 << FRAC_BITS));
    m.distance_cm     = {window_q[4], window_q[3]};
    m.signal_strength = window_q[5];
    // A match restarts collection of the next packet from an empty window.
    fill_q = 0;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    meas_t want;
    if (!rst_ni) begin
      fill_q = 0;
      meas_queue.delete();
      pending_o <= 0;
    end else begin
      if (rx_valid_i && rx_ready_i) begin
        if (absorb_byte(rx_byte_i, want)) meas_queue.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        if (meas_queue.size() == 0) begin
          report_mismatch("measurement transaction with no expected measurement");
        end else begin
          want = meas_queue.pop_front();
          compare_field("sync_byte", sync_byte_i, want.sync_byte);
          compare_field("angle_fixed", angle_fixed_i, want.angle_fixed);
          compare_field("degree_index", degree_index_i, want.degree_index);
          compare_field("angle_in_range", angle_in_range_i, want.angle_in_range);
          compare_field("distance_cm", distance_cm_i, want.distance_cm);
          compare_field("signal_strength", signal_strength_i, want.signal_strength);
        end
      end
      pending_o <= meas_queue.size();
    end
  end

endmodule

// File: tb/tb_lidar_packet_sync_parser_unit.sv
`timescale 1ns / 1ps

module tb_lidar_packet_sync_parser_unit;

  localparam int unsigned BYTE_TARGET  = 650;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned IDLE_PCT     = 29;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PKT_LEN      = 7;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        rx_valid_i  = 1'b0;
  logic        rx_ready_o;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  sync_byte_o;
  logic [15:0] angle_fixed_o;
  logic [11:0] degree_index_o;
  logic        angle_in_range_o;
  logic [15:0] distance_cm_o;
  logic [7:0]  signal_strength_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned bytes_sent  = 0;
  int unsigned cycle_count = 0;
  bit          steady      = 1'b0;

  always #5 clk_i = ~clk_i;

  lidar_packet_sync_parser_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_valid_i       (rx_valid_i),
    .rx_ready_o       (rx_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sync_byte_o      (sync_byte_o),
    .angle_fixed_o    (angle_fixed_o),
    .degree_index_o   (degree_index_o),
    .angle_in_range_o (angle_in_range_o),
    .distance_cm_o    (distance_cm_o),
    .signal_strength_o(signal_strength_o)
  );

  lidar_packet_sync_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_valid_i       (rx_valid_i),
    .rx_ready_i       (rx_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sync_byte_i      (sync_byte_o),
    .angle_fixed_i    (angle_fixed_o),
    .degree_index_i   (degree_index_o),
    .angle_in_range_i (angle_in_range_o),
    .distance_cm_i    (distance_cm_o),
    .signal_strength_i(signal_strength_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_lidar_packet_sync_parser_unit failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Holds the byte on the channel until the transaction completes.
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      rx_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!rx_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Sends the first count bytes of a packet; corrupt flips one random bit.
  task automatic send_packet(input logic [7:0] sync, input logic [15:0] angle,
                             input logic [15:0] distance, input logic [7:0] strength,
                             input int unsigned count, input bit corrupt);
    logic [7:0]  pkt [PKT_LEN];
    int unsigned total;
    pkt[0] = sync;
    pkt[1] = angle[7:0];
    pkt[2] = angle[15:8];
    pkt[3] = distance[7:0];
    pkt[4] = distance[15:8];
    pkt[5] = strength;
    total = 0;
    for (int k = 0; k < PKT_LEN - 1; k++) total += pkt[k];
    pkt[6] = 8'(total % 255);
    if (corrupt) pkt[$urandom_range(0, PKT_LEN - 1)] ^= 8'(1 << $urandom_range(0, 7));
    for (int k = 0; k < count; k++) send_byte(pkt[k]);
  endtask

  task automatic random_packet(input int unsigned count, input bit corrupt);
    logic [15:0] angle;
    logic [15:0] distance;
    case ($urandom_range(0, 3))
      0:       angle = 16'($urandom_range(5750, 5770));
      1:       angle = 16'($urandom);
      default: angle = 16'($urandom_range(0, 5759));
    endcase
    case ($urandom_range(0, 7))
      0:       distance = 16'h0000;
      1:       distance = 16'hFFFF;
      default: distance = 16'($urandom);
    endcase
    send_packet(8'($urandom), angle, distance, 8'($urandom), count, corrupt);
  endtask

  initial begin : stimulus
    bit          paused;
    int unsigned pick;
    paused = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes and both sides of the azimuth range boundary.
    send_packet(8'h00, 16'h0000, 16'h0000, 8'h00, PKT_LEN, 1'b0);
    send_packet(8'h01, 16'd5759, 16'h0001, 8'h7F, PKT_LEN, 1'b0);
    send_packet(8'hFE, 16'd5760, 16'h8000, 8'h80, PKT_LEN, 1'b0);
    send_packet(8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, PKT_LEN, 1'b0);

    while (bytes_sent < BYTE_TARGET) begin
      steady = (bytes_sent >= 300 && bytes_sent < 420);
      if (!paused && bytes_sent >= 500) begin
        // Let every measurement drain before the stream resumes.
        rx_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        random_packet(PKT_LEN, 1'b0);
      end else if (pick < 85) begin
        // Noise, often with 0xFF bytes that can never serve as a checksum.
        repeat ($urandom_range(1, 6)) begin
          send_byte(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
        end
      end else if (pick < 93) begin
        random_packet(PKT_LEN, 1'b1);
      end else begin
        random_packet($urandom_range(1, PKT_LEN - 1), 1'b0);
      end
    end
    steady = 1'b0;
    rx_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("tb_lidar_packet_sync_parser_unit passed");
    end else begin
      $display("tb_lidar_packet_sync_parser_unit failed");
    end
    $finish;
  end

endmodule
